>>> rtl/aqs_pkg.sv
// ============================================================================
// aqs_pkg
// Shared widths and controller/datapath command and status types for the
// aliquot sum block.
// ============================================================================
package aqs_pkg;

    localparam int NUM_W      = 10;               // number / table index width
    localparam int TABLE_SIZE = 1 << NUM_W;       // factor table depth
    localparam int SUM_W      = 12;               // divisor sum width
    localparam int CNT_W      = $clog2(NUM_W);    // divider step counter
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;     // clear table entry i, advance i (wraps to 2)
        logic scan_rd;    // read table[i]
        logic prime_wr;   // table[i] = i, j = i*i
        logic i_next;     // i = i + 1
        logic mark_rd;    // read table[j]
        logic mark_wr;    // table[j] = i if empty, j = j + i
        logic load;       // take a new number
        logic look_rd;    // read table[rest]
        logic group;      // fold factor into series, start divide
        logic div_step;   // one restoring divide step
        logic close;      // sigma = sigma * series
        logic out_load;   // load result word
    } aqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rd_zero;    // read entry is still empty
        logic i_last;     // i at last table index
        logic sq_in;      // i*i inside table
        logic j_in;       // j+i inside table
        logic div_last;   // final divide step
        logic quo_one;    // quotient of final step is one
        logic num_small;  // incoming number below two
        logic out_free;   // result register can take a word
    } aqs_status_t;

endpackage

>>> rtl/aliquot_sum_by_spf_sieve.sv
// ============================================================================
// aliquot_sum_by_spf_sieve
// Proper divisor sum sigma(n) - n via a smallest-prime-factor sieve table.
// ============================================================================
// Flow: per prime factor (counted with multiplicity) a table read, a group
//   step and the 10-step serial divider; n below two goes straight to close.
// Throughput: one number at a time; s_tready returns only after the result
//   word is loaded, which waits while the result register is still full.
// Reset: synchronous, active low. Afterwards the table is cleared and
//   sieved; s_tready stays low until done.
// ============================================================================
module aliquot_sum_by_spf_sieve (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [aqs_pkg::S_TDATA_W-1:0] s_tdata,   // [9:0] number, rest zero
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [aqs_pkg::M_TDATA_W-1:0] m_tdata    // [11:0] proper_divisor_sum
);
    import aqs_pkg::*;

    aqs_cmd_t         cmd;
    aqs_status_t      status;
    logic [SUM_W-1:0] out_sum;

    // Controller: walks the sieve after reset, then per number runs
    // lookup -> group -> divide steps until the remaining cofactor is one.
    aqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: 1024 x 10 table memory, serial divider, series and sigma
    // multipliers, and the result register that decouples the m_ side.
    aqs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .num       (s_tdata[NUM_W-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (out_sum)
    );

    // result word, zero padded up to whole bytes
    assign m_tdata = {{(M_TDATA_W - SUM_W){1'b0}}, out_sum};

endmodule

>>> rtl/aqs_dp.sv
// ============================================================================
// aqs_dp
// Datapath: factor table memory, sieve counters, bit-serial divider,
// series/sigma accumulators and result register.
// ============================================================================
module aqs_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  aqs_pkg::aqs_cmd_t         cmd,
    output aqs_pkg::aqs_status_t      status,
    input  logic [aqs_pkg::NUM_W-1:0] num,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [aqs_pkg::SUM_W-1:0] out_sum
);
    import aqs_pkg::*;

    logic [NUM_W-1:0]   mem [TABLE_SIZE];
    logic [NUM_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic [NUM_W-1:0]   mem_wa;
    logic [NUM_W-1:0]   mem_wd;
    logic               mem_re;
    logic [NUM_W-1:0]   mem_ra;

    logic [NUM_W-1:0]   i_reg;
    logic [NUM_W:0]     j_reg;
    logic [2*NUM_W-1:0] i_sq;
    logic [NUM_W+1:0]   j_sum;

    logic [NUM_W-1:0]   n_reg;
    logic [NUM_W-1:0]   rest_reg;
    logic [NUM_W-1:0]   p_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   sigma_reg;
    logic [SUM_W-1:0]   series_reg;
    logic [SUM_W-1:0]   power_reg;
    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_sum_reg;

    logic [NUM_W:0]     rem_sh;
    logic               rem_ge;
    logic [NUM_W:0]     rem_sub;
    logic [NUM_W-1:0]   quo_step;
    logic [SUM_W+NUM_W-1:0] pow_prod;
    logic [2*SUM_W-1:0] sig_prod;

    assign i_sq  = i_reg * i_reg;
    assign j_sum = {1'b0, j_reg} + {2'b00, i_reg};

    // table write / read selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = i_reg;
        mem_wd = i_reg;
        if (cmd.clr_wr) begin
            mem_we = 1'b1;
            mem_wd = (i_reg[NUM_W-1:1] == '0) ? NUM_W'(1) : '0;
        end else if (cmd.prime_wr) begin
            mem_we = 1'b1;
        end else if (cmd.mark_wr && status.rd_zero) begin
            mem_we = 1'b1;
            mem_wa = j_reg[NUM_W-1:0];
        end
        mem_re = cmd.scan_rd | cmd.mark_rd | cmd.look_rd;
        mem_ra = cmd.mark_rd ? j_reg[NUM_W-1:0] : (cmd.look_rd ? rest_reg : i_reg);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // restoring divide of rest by p, one quotient bit a step, in place
    assign rem_sh   = {rem_reg, rest_reg[NUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, p_reg};
    assign rem_sub  = rem_sh - {1'b0, p_reg};
    assign quo_step = {rest_reg[NUM_W-2:0], rem_ge};

    assign pow_prod = power_reg * rd_data_reg;
    assign sig_prod = sigma_reg * series_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg <= '0;
        end else if (cmd.clr_wr) begin
            i_reg <= status.i_last ? NUM_W'(2) : i_reg + NUM_W'(1);
        end else if (cmd.i_next) begin
            i_reg <= i_reg + NUM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prime_wr) begin
            j_reg <= i_sq[NUM_W:0];
        end else if (cmd.mark_wr) begin
            j_reg <= j_sum[NUM_W:0];
        end

        if (cmd.load) begin
            n_reg      <= num;
            rest_reg   <= num;
            p_reg      <= '0;
            sigma_reg  <= SUM_W'(1);
            series_reg <= SUM_W'(1);
            power_reg  <= SUM_W'(1);
        end else if (cmd.group) begin
            rem_reg <= '0;
            cnt_reg <= '0;
            if (rd_data_reg == p_reg) begin
                power_reg  <= pow_prod[SUM_W-1:0];
                series_reg <= series_reg + pow_prod[SUM_W-1:0];
            end else begin
                sigma_reg  <= sig_prod[SUM_W-1:0];
                p_reg      <= rd_data_reg;
                power_reg  <= SUM_W'(rd_data_reg);
                series_reg <= SUM_W'(rd_data_reg) + SUM_W'(1);
            end
        end else if (cmd.div_step) begin
            rem_reg  <= rem_ge ? rem_sub[NUM_W-1:0] : rem_sh[NUM_W-1:0];
            rest_reg <= quo_step;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end else if (cmd.close) begin
            sigma_reg <= sig_prod[SUM_W-1:0];
        end
    end

    // result register: takes a word whenever the previous one leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_sum_reg <= (n_reg[NUM_W-1:1] == '0) ? '0
                         : sigma_reg - SUM_W'(n_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

    always_comb begin
        status.rd_zero   = (rd_data_reg == '0);
        status.i_last    = (i_reg == NUM_W'(TABLE_SIZE - 1));
        status.sq_in     = (i_sq[2*NUM_W-1:NUM_W] == '0);
        status.j_in      = (j_sum[NUM_W+1:NUM_W] == '0);
        status.div_last  = (cnt_reg == CNT_W'(NUM_W - 1));
        status.quo_one   = (quo_step == NUM_W'(1));
        status.num_small = (num[NUM_W-1:1] == '0);
        status.out_free  = !out_valid_reg || out_ready;
    end

endmodule

>>> rtl/aqs_ctrl.sv
// ============================================================================
// aqs_ctrl
// Controller: sieve sequencing after reset, then per-number factoring steps.
// ============================================================================
module aqs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aqs_pkg::aqs_status_t status,
    output aqs_pkg::aqs_cmd_t    cmd
);
    import aqs_pkg::*;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_NEXT,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_IDLE,
        ST_LOOK,
        ST_GROUP,
        ST_DIV,
        ST_CLOSE,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_wr = 1'b1;
                if (status.i_last) state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (status.rd_zero) begin
                    cmd.prime_wr = 1'b1;
                    state_next   = status.sq_in ? ST_MARK_RD : ST_NEXT;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (status.i_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.i_next = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MARK_RD: begin
                cmd.mark_rd = 1'b1;
                state_next  = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                cmd.mark_wr = 1'b1;
                state_next  = status.j_in ? ST_MARK_RD : ST_NEXT;
            end
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.num_small ? ST_CLOSE : ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.look_rd = 1'b1;
                state_next  = ST_GROUP;
            end
            ST_GROUP: begin
                cmd.group  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = status.quo_one ? ST_CLOSE : ST_LOOK;
            end
            ST_CLOSE: begin
                cmd.close  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

>>> rtl/aqs_checker.sv
// ============================================================================
// aqs_checker
// Port-level checks for the aliquot sum block, bound to the top level.
// ============================================================================
module aqs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [aqs_pkg::M_TDATA_W-1:0] m_tdata
);
    import aqs_pkg::*;

    // result register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

    // table build must follow reset before any word is taken
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during table build");

    // one number at a time: busy right after taking a word
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accepting a word");

    // a new result appears only out of the busy phase
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result word without work");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind aliquot_sum_by_spf_sieve aqs_checker u_aqs_checker (.*);

>>> tb/sv/tb_aliquot_sum_by_spf_sieve.sv
// ============================================================================
// tb_aliquot_sum_by_spf_sieve
// Self-checking bench: feeds numbers into the aliquot sum block and compares
// every returned sum with a sieve-based predictor kept inside the bench.
// ============================================================================
module tb_aliquot_sum_by_spf_sieve;
    timeunit 1ns;
    timeprecision 1ps;

    import aqs_pkg::*;

    localparam int SUM_MAX        = (1 << SUM_W) - 1;
    localparam int N_PROBES       = 24;
    localparam int RANDOM_NUMBERS = 2000;
    // no-idle stretch and receiver hold-off, both keyed to words accepted
    localparam int STEADY_FROM    = 800;
    localparam int STEADY_TO      = 1100;
    localparam int HOLD_AT        = 1500;
    localparam int HOLD_CYCLES    = 400;
    // watchdog limit; must cover the clear plus sieve after reset and the worst number
    localparam int STUCK_LIMIT    = 40000;
    localparam int TAIL_CYCLES    = 150;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [9:0] number, rest zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [11:0] proper_divisor_sum, rest zero

    aliquot_sum_by_spf_sieve dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Directed probes. Sum typed in only where it is obvious (zero, one,
    // primes); the rest go through the predictor.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             known;
        logic [SUM_W-1:0] sum;
    } probe_t;

    probe_t probes [N_PROBES] = '{
        '{10'd0,    1'b1, 12'd0},   // zero behaves like one
        '{10'd1,    1'b1, 12'd0},   // one has no proper divisors
        '{10'd2,    1'b1, 12'd1},   // smallest prime
        '{10'd1021, 1'b1, 12'd1},   // largest prime in range
        '{10'd1023, 1'b0, 12'd0},   // all ones: 3 * 11 * 31
        '{10'd3,    1'b0, 12'd0},
        '{10'd4,    1'b0, 12'd0},
        '{10'd6,    1'b0, 12'd0},   // perfect
        '{10'd28,   1'b0, 12'd0},   // perfect
        '{10'd496,  1'b0, 12'd0},   // perfect
        '{10'd220,  1'b0, 12'd0},   // amicable pair
        '{10'd284,  1'b0, 12'd0},
        '{10'd512,  1'b0, 12'd0},   // 2^9, longest factor walk
        '{10'd729,  1'b0, 12'd0},   // 3^6
        '{10'd625,  1'b0, 12'd0},   // 5^4
        '{10'd343,  1'b0, 12'd0},   // 7^3
        '{10'd961,  1'b0, 12'd0},   // 31^2, largest prime square in range
        '{10'd720,  1'b0, 12'd0},
        '{10'd840,  1'b0, 12'd0},
        '{10'd960,  1'b0, 12'd0},
        '{10'd1008, 1'b0, 12'd0},   // largest sum in range
        '{10'd1000, 1'b0, 12'd0},
        '{10'd1022, 1'b0, 12'd0},
        '{10'd1020, 1'b0, 12'd0}
    };

    // ------------------------------------------------------------------------
    // Predictor: own smallest-factor sieve plus geometric series product
    // ------------------------------------------------------------------------
    logic [NUM_W-1:0] spf_table [TABLE_SIZE];

    task automatic fill_factor_table();
        int i;
        int j;
        for (i = 0; i < TABLE_SIZE; i++)
            spf_table[i] = (i < 2) ? NUM_W'(1) : NUM_W'(0);
        for (i = 2; i < TABLE_SIZE; i++) begin
            if (spf_table[i] != 0)
                continue;
            spf_table[i] = NUM_W'(i);
            for (j = i * i; j < TABLE_SIZE; j += i)
                if (spf_table[j] == 0)
                    spf_table[j] = NUM_W'(i);
        end
    endtask

    function automatic logic [SUM_W-1:0] aliquot_of(input logic [NUM_W-1:0] n);
        int unsigned rest;
        int unsigned sigma;
        int unsigned p;
        int unsigned series;
        int unsigned power;
        rest  = n;
        sigma = 1;
        if (n < 2)
            return '0;
        while (rest > 1) begin
            p = spf_table[rest];
            if (p < 2)
                break;
            series = 1;
            power  = 1;
            // 1 + p + ... + p^k, built term by term
            while (rest % p == 0) begin
                rest   = rest / p;
                power  = power * p;
                series = series + power;
            end
            sigma = sigma * series;
        end
        sigma = sigma - n;
        return (sigma > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(sigma);
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------------
    typedef struct {
        logic [NUM_W-1:0] number;
        logic [SUM_W-1:0] sum;
    } sum_due_t;

    sum_due_t pending_sums [$];
    int       numbers_in;
    int       sums_out;
    int       failures;
    int       hold_word;

    // typed-in sum for the word now on the input bus
    logic             row_known;
    logic [SUM_W-1:0] row_sum;

    function automatic bit in_steady_window();
        return numbers_in >= STEADY_FROM && numbers_in < STEADY_TO;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Monitor: result check first, then queue the sum for an accepted number.
    // Results are registered after the number is taken: no word matches itself.
    // ------------------------------------------------------------------------
    initial begin
        numbers_in = 0;
        sums_out   = 0;
        failures   = 0;
    end

    always @(posedge aclk) begin
        sum_due_t due;
        if (aresetn && m_tvalid && m_tready) begin
            sums_out++;
            if (pending_sums.size() == 0) begin
                failures++;
                $display("%0t: unexpected result word, got sum %0d", $time,
                         m_tdata[SUM_W-1:0]);
            end else begin
                due = pending_sums.pop_front();
                if (m_tdata !== {{(M_TDATA_W-SUM_W){1'b0}}, due.sum}) begin
                    failures++;
                    $display("%0t: sum of %0d: expected %0d (0x%h), got 0x%h",
                             $time, due.number, due.sum, due.sum, m_tdata);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            numbers_in++;
            due.number = s_tdata[NUM_W-1:0];
            due.sum    = row_known ? row_sum : aliquot_of(s_tdata[NUM_W-1:0]);
            pending_sums.push_back(due);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ~20% random stall, none in the steady window, and one long
    // hold-off so the block backs up and drops s_tready.
    // ------------------------------------------------------------------------
    initial begin
        bit held;
        held      = 1'b0;
        hold_word = -1;
        m_tready  = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held && numbers_in >= HOLD_AT) begin
                held      = 1'b1;
                hold_word = numbers_in;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= in_steady_window() || ($urandom_range(0, 99) >= 20);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no word moving on either side
    // ------------------------------------------------------------------------
    initial begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t: no word moved for %0d cycles, %0d sums outstanding",
                 $time, STUCK_LIMIT, pending_sums.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: offer one number, idle ~20% of cycles outside the steady
    // window. Inputs move on the falling edge only.
    // ------------------------------------------------------------------------
    task automatic offer_number(input logic [NUM_W-1:0] n, input logic known,
                                input logic [SUM_W-1:0] sum);
        while (!in_steady_window() && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {{(S_TDATA_W-NUM_W){1'b0}}, n};
        row_known <= known;
        row_sum   <= sum;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [NUM_W-1:0] n;
        int               pick;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        row_known = 1'b0;
        row_sum   = '0;
        fill_factor_table();

        // one reset; the block then clears and sieves its table
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed probes
        for (int k = 0; k < N_PROBES; k++)
            offer_number(probes[k].number, probes[k].known, probes[k].sum);

        // random numbers, a tenth of them tiny to hit 0/1/small primes often
        for (int k = 0; k < RANDOM_NUMBERS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                n = NUM_W'($urandom_range(0, 15));
            else
                n = NUM_W'($urandom_range(0, TABLE_SIZE - 1));
            offer_number(n, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain, then a tail long enough for a stray late word to show up
        while (pending_sums.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (pending_sums.size() != 0) begin
            failures++;
            $display("%0t: %0d sums never returned", $time, pending_sums.size());
        end

        $display("Summary: %0d numbers in (%0d directed, %0d random), %0d sums out, %0d bad",
                 numbers_in, N_PROBES, RANDOM_NUMBERS, sums_out, failures);
        $display("Summary: no-idle stretch over words %0d-%0d, %0d-cycle %s %0d",
                 STEADY_FROM, STEADY_TO, HOLD_CYCLES, "output hold-off at word",
                 hold_word);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/aqs_pkg.sv
rtl/aqs_dp.sv
rtl/aqs_ctrl.sv
rtl/aliquot_sum_by_spf_sieve.sv
rtl/aqs_checker.sv
tb/sv/tb_aliquot_sum_by_spf_sieve.sv
